FILE: rtl/multi_stream_lehmer_rng_top_assert.svh
// Assertion macros for the multi-stream Lehmer generator.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef MULTI_STREAM_LEHMER_RNG_TOP_ASSERT_SVH
`define MULTI_STREAM_LEHMER_RNG_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MSL_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define MSL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MSL_ASSERT(label, clk, rstn, prop, msg)
`define MSL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/mslrng_pkg.sv
// Shared types, constants and the default seed table of the Lehmer generator.
// No dependencies.
`timescale 1ns / 1ps

package mslrng_pkg;

    localparam int STREAM_COUNT       = 101;
    localparam int SEED_IDX_W         = $clog2(STREAM_COUNT);
    localparam int DEFAULT_SEED_COUNT = 101;
    localparam int DSEED_IDX_W        = $clog2(DEFAULT_SEED_COUNT);

    localparam int SEED_W   = 31;
    localparam int FRAC_W   = 24;
    localparam int VALUE_W  = 16;
    localparam int FUNC_W   = 2;
    localparam int STREAM_W = 7;
    localparam int SPAN_W   = VALUE_W + 1;
    localparam int PROD_W   = SEED_W + 30;
    localparam int RPROD_W  = SPAN_W + FRAC_W;

    localparam logic [SEED_W-1:0] PRIME_MOD  = 31'h7FFF_FFFF;
    localparam logic [29:0]       LEHMER_MUL = 30'd630360016;

    typedef logic [SEED_W-1:0]     seed_t;
    typedef logic [SEED_IDX_W-1:0] seed_idx_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_DRAW = 2'd0,
        FUNC_SET  = 2'd1,
        FUNC_READ = 2'd2
    } func_t;

    typedef struct packed {
        logic      en;
        seed_idx_t addr;
    } seed_rd_t;

    typedef struct packed {
        logic      en;
        seed_idx_t addr;
        seed_t     data;
    } seed_wr_t;

    localparam seed_t DEFAULT_SEED_TAB [DEFAULT_SEED_COUNT] = '{
        31'd1,
        31'd1973272912, 31'd281629770,  31'd20006270,   31'd1280689831, 31'd2096730329,
        31'd1933576050, 31'd913566091,  31'd246780520,  31'd1363774876, 31'd604901985,
        31'd1511192140, 31'd1259851944, 31'd824064364,  31'd150493284,  31'd242708531,
        31'd75253171,   31'd1964472944, 31'd1202299975, 31'd233217322,  31'd1911216000,
        31'd726370533,  31'd403498145,  31'd993232223,  31'd1103205531, 31'd762430696,
        31'd1922803170, 31'd1385516923, 31'd76271663,   31'd413682397,  31'd726466604,
        31'd336157058,  31'd1432650381, 31'd1120463904, 31'd595778810,  31'd877722890,
        31'd1046574445, 31'd68911991,   31'd2088367019, 31'd748545416,  31'd622401386,
        31'd2122378830, 31'd640690903,  31'd1774806513, 31'd2132545692, 31'd2079249579,
        31'd78130110,   31'd852776735,  31'd1187867272, 31'd1351423507, 31'd1645973084,
        31'd1997049139, 31'd922510944,  31'd2045512870, 31'd898585771,  31'd243649545,
        31'd1004818771, 31'd773686062,  31'd403188473,  31'd372279877,  31'd1901633463,
        31'd498067494,  31'd2087759558, 31'd493157915,  31'd597104727,  31'd1530940798,
        31'd1814496276, 31'd536444882,  31'd1663153658, 31'd855503735,  31'd67784357,
        31'd1432404475, 31'd619691088,  31'd119025595,  31'd880802310,  31'd176192644,
        31'd1116780070, 31'd277854671,  31'd1366580350, 31'd1142483975, 31'd2026948561,
        31'd1053920743, 31'd786262391,  31'd1792203830, 31'd1494667770, 31'd1923011392,
        31'd1433700034, 31'd1244184613, 31'd1147297105, 31'd539712780,  31'd1545929719,
        31'd190641742,  31'd1645390429, 31'd264907697,  31'd620389253,  31'd1502074852,
        31'd927711160,  31'd364849192,  31'd2049576050, 31'd638580085,  31'd547070247
    };

    function automatic seed_t default_seed(input seed_idx_t idx);
        logic [31:0] wide;
        seed_t       r;
        wide = 32'(idx);
        if (wide < DEFAULT_SEED_COUNT) begin
            r = DEFAULT_SEED_TAB[wide[DSEED_IDX_W-1:0]];
        end else begin
            r = 31'd1;
        end
        return r;
    endfunction

endpackage

FILE: rtl/multi_stream_lehmer_rng_top.sv
// Multi-stream Lehmer generator (mod 2^31-1): each transaction draws, sets or
// reads one of STREAM_COUNT seeds. A transaction is accepted when the block is
// idle and its result lands in the output register once that register is free;
// the next transaction can be accepted while that result waits. A transaction
// holds in turn the seed-table read, the two-stage modular multiply and the
// range multiply, and no new one is accepted until it is through them. The
// table comes out of reset with its default seeds at once; no clearing pass.
// Depends on mslrng_pkg, mslrng_seed_mem and mslrng_lehmer.
`timescale 1ns / 1ps
`include "multi_stream_lehmer_rng_top_assert.svh"

module multi_stream_lehmer_rng_top import mslrng_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [STREAM_W-1:0] s_stream,
    input  logic [SEED_W-1:0]   s_new_seed,
    input  logic [VALUE_W-1:0]  s_lower,
    input  logic [VALUE_W-1:0]  s_upper,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SEED_W-1:0]   m_seed_out,
    output logic [FRAC_W-1:0]   m_fraction,
    output logic [VALUE_W-1:0]  m_value
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_FOLD,
        ST_RANGE
    } state_t;

    state_t               state_reg;
    logic [FUNC_W-1:0]    func_reg;
    seed_idx_t            idx_reg;
    logic                 in_range_reg;
    seed_t                new_seed_reg;
    logic [VALUE_W-1:0]   lower_reg;
    logic [VALUE_W-1:0]   upper_reg;
    logic                 draw_reg;
    logic                 range_ok_reg;
    seed_t                res_seed_reg;
    logic [FRAC_W-1:0]    frac_reg;
    logic [RPROD_W-1:0]   rprod_reg;
    logic                 m_valid_reg;
    seed_t                m_seed_out_reg;
    logic [FRAC_W-1:0]    m_fraction_reg;
    logic [VALUE_W-1:0]   m_value_reg;

    logic                 accept;
    logic                 s_in_range;
    seed_rd_t             mem_rd;
    seed_wr_t             mem_wr;
    seed_t                mem_rd_data;
    seed_t                lehmer_z;
    logic                 is_draw;
    logic [FRAC_W-1:0]    frac_calc;
    logic [SPAN_W-1:0]    span;
    logic [RPROD_W-1:0]   rprod_next;
    seed_t                res_seed_next;
    logic [VALUE_W-1:0]   value_calc;
    logic                 out_free;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign s_in_range = (32'(s_stream) < STREAM_COUNT);
    assign out_free   = !m_valid_reg || m_ready;

    assign mem_rd.en   = accept && s_in_range;
    assign mem_rd.addr = SEED_IDX_W'(s_stream);

    mslrng_seed_mem u_seed_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (mem_rd),
        .wr      (mem_wr),
        .rd_data (mem_rd_data)
    );

    mslrng_lehmer u_lehmer (
        .aclk (aclk),
        .seed (mem_rd_data),
        .z    (lehmer_z)
    );

    assign is_draw   = in_range_reg && (func_reg == FUNC_DRAW);
    assign frac_calc = lehmer_z[SEED_W-1:7] | FRAC_W'(1);
    assign span      = SPAN_W'(upper_reg) + SPAN_W'(1) - SPAN_W'(lower_reg);
    assign rprod_next = RPROD_W'(span) * RPROD_W'(frac_calc);

    always_comb begin
        mem_wr.en   = 1'b0;
        mem_wr.addr = idx_reg;
        mem_wr.data = new_seed_reg;
        if (state_reg == ST_FOLD && in_range_reg) begin
            case (func_reg)
                FUNC_DRAW: begin
                    mem_wr.en   = 1'b1;
                    mem_wr.data = lehmer_z;
                end
                FUNC_SET: begin
                    mem_wr.en = 1'b1;
                end
                default: begin
                    mem_wr.en = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        res_seed_next = '0;
        if (in_range_reg) begin
            case (func_reg)
                FUNC_DRAW: res_seed_next = lehmer_z;
                FUNC_SET:  res_seed_next = new_seed_reg;
                FUNC_READ: res_seed_next = mem_rd_data;
                default:   res_seed_next = '0;
            endcase
        end
    end

    assign value_calc = range_ok_reg
                      ? VALUE_W'(SPAN_W'(lower_reg) + rprod_reg[RPROD_W-1:FRAC_W])
                      : lower_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_RANGE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        func_reg     <= s_func;
                        idx_reg      <= SEED_IDX_W'(s_stream);
                        in_range_reg <= s_in_range;
                        new_seed_reg <= s_new_seed;
                        lower_reg    <= s_lower;
                        upper_reg    <= s_upper;
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_FOLD;
                end
                ST_FOLD: begin
                    draw_reg     <= is_draw;
                    range_ok_reg <= (upper_reg >= lower_reg);
                    res_seed_reg <= res_seed_next;
                    frac_reg     <= frac_calc;
                    rprod_reg    <= rprod_next;
                    state_reg    <= ST_RANGE;
                end
                ST_RANGE: begin
                    if (out_free) begin
                        m_seed_out_reg <= res_seed_reg;
                        m_fraction_reg <= draw_reg ? frac_reg : '0;
                        m_value_reg    <= draw_reg ? value_calc : '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_seed_out = m_seed_out_reg;
    assign m_fraction = m_fraction_reg;
    assign m_value    = m_value_reg;

    `MSL_ASSERT(a_single_transaction, aclk, aresetn, accept |=> !s_ready, "second transaction accepted while busy")
    `MSL_ASSERT(a_seed_reduced, aclk, aresetn, (state_reg == ST_FOLD && is_draw) |-> (lehmer_z < PRIME_MOD), "drawn seed not reduced mod 2^31-1")
    `MSL_ASSERT(a_value_in_range, aclk, aresetn, (state_reg == ST_RANGE && draw_reg && range_ok_reg) |-> (value_calc >= lower_reg && value_calc <= upper_reg), "uniform value outside requested range")

endmodule

FILE: rtl/mslrng_seed_mem.sv
// Seed table: one write port, one registered read port, per-entry valid bits.
// Entries never written read back as the default seed. Depends on mslrng_pkg.
`timescale 1ns / 1ps
`include "multi_stream_lehmer_rng_top_assert.svh"

module mslrng_seed_mem import mslrng_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  seed_rd_t rd,
    input  seed_wr_t wr,
    output seed_t    rd_data
);

    seed_t                   mem_reg [STREAM_COUNT];
    logic [STREAM_COUNT-1:0] valid_reg;
    seed_t                   rd_data_reg;
    seed_t                   rd_dflt_reg;
    logic                    rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_reg[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= mem_reg[rd.addr];
            rd_dflt_reg <= default_seed(rd.addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                rd_hit_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : rd_dflt_reg;

    `MSL_ASSERT(a_no_rw_overlap, aclk, aresetn, !(rd.en && wr.en), "seed table read and write overlap")
    `MSL_ASSERT(a_write_marks_valid, aclk, aresetn, wr.en |=> valid_reg[$past(wr.addr)], "written entry not marked valid")

endmodule

FILE: rtl/mslrng_lehmer.sv
// Two-stage Lehmer step: seed * 630360016, then Mersenne fold mod 2^31-1.
// Depends on mslrng_pkg.
`timescale 1ns / 1ps

module mslrng_lehmer import mslrng_pkg::*; (
    input  logic  aclk,
    input  seed_t seed,
    output seed_t z
);

    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;
    logic [31:0]       fold_sum;
    seed_t             z_next;
    seed_t             z_reg;

    assign prod_next = PROD_W'(seed) * PROD_W'(LEHMER_MUL);

    assign fold_sum = 32'(prod_reg[PROD_W-1:SEED_W]) + 32'(prod_reg[SEED_W-1:0]);
    assign z_next   = (fold_sum >= 32'(PRIME_MOD)) ? SEED_W'(fold_sum - 32'(PRIME_MOD))
                                                   : fold_sum[SEED_W-1:0];

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        z_reg    <= z_next;
    end

    assign z = z_reg;

endmodule
